### src/ebsd_pkg.sv
package ebsd_pkg;

  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 9;
  localparam int KIND_W   = 2;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = LEN_W;

  localparam int DEF_MAX_FRAME_BYTES = 256;
  localparam int DEF_QUEUE_DEPTH     = 4;

  localparam logic [BYTE_W-1:0] RST_START_BYTE  = 8'h01;
  localparam logic [BYTE_W-1:0] RST_STOP_BYTE   = 8'hFE;
  localparam logic [BYTE_W-1:0] RST_ESCAPE_BYTE = 8'h27;
  localparam logic [LEN_W-1:0]  RST_FRAME_LIMIT = 9'd256;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_BYTE  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_BYTE   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_BYTE = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_LIMIT = 8'd3;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_DATA  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_END   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ABORT = 2'd2;
  localparam logic [KIND_W-1:0] KIND_OVER  = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
    logic              is_start;
    logic              is_escape;
    logic              is_stop;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } q_head_t;

endpackage

### src/ebsd_front.sv
module ebsd_front (
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [ebsd_pkg::BYTE_W-1:0]  rx_byte,
  input  logic [ebsd_pkg::BYTE_W-1:0]  start_byte,
  input  logic [ebsd_pkg::BYTE_W-1:0]  stop_byte,
  input  logic [ebsd_pkg::BYTE_W-1:0]  escape_byte,
  input  logic                         q_full,
  output logic                         q_push,
  output ebsd_pkg::entry_t             q_entry
);
  import ebsd_pkg::*;

  // flags settled here; user must hold config still while items are in flight, not enforced
  always_comb begin
    q_entry.rx_byte   = rx_byte;
    q_entry.is_start  = (rx_byte == start_byte);
    q_entry.is_escape = (rx_byte == escape_byte);
    q_entry.is_stop   = (rx_byte == stop_byte);
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

endmodule

### src/ebsd_queue.sv
module ebsd_queue #(
  parameter int DEPTH = ebsd_pkg::DEF_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ebsd_pkg::entry_t  push_entry,
  output logic              full,
  input  logic              pop,
  output ebsd_pkg::q_head_t head
);
  import ebsd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] DepthCnt = CNT_W'(DEPTH);
  localparam logic [PTR_W-1:0] LastPtr  = PTR_W'(DEPTH - 1);

  entry_t           mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == DepthCnt);
  assign head.valid = (count != '0);
  assign head.entry = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### src/ebsd_back.sv
module ebsd_back #(
  parameter int MAX_FRAME_BYTES = ebsd_pkg::DEF_MAX_FRAME_BYTES
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ebsd_pkg::q_head_t           head,
  output logic                        pop,
  input  logic [ebsd_pkg::LEN_W-1:0]  frame_limit,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ebsd_pkg::KIND_W-1:0] kind,
  output logic [ebsd_pkg::BYTE_W-1:0] data_byte,
  output logic [ebsd_pkg::LEN_W-1:0]  frame_length
);
  import ebsd_pkg::*;

  // cap is only used when the parameter is below the register's range
  localparam logic [LEN_W-1:0] CapLimit = LEN_W'(MAX_FRAME_BYTES);

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_RX   = 2'd1,
    ST_ESC  = 2'd2
  } state_t;

  state_t             state;
  state_t             state_next;
  logic [LEN_W-1:0]   byte_count;
  logic [LEN_W-1:0]   byte_count_next;
  logic [LEN_W-1:0]   limit;
  logic [LEN_W-1:0]   count_inc;
  logic               emit;
  logic [KIND_W-1:0]  kind_next;
  logic [BYTE_W-1:0]  data_next;
  logic [LEN_W-1:0]   length_next;
  logic               payload;
  entry_t             e;

  assign e   = head.entry;
  assign pop = head.valid && (!out_valid || !out_stall);

  always_comb begin
    if (32'(frame_limit) > 32'(MAX_FRAME_BYTES)) begin
      limit = CapLimit;
    end else begin
      limit = frame_limit;
    end
  end

  assign count_inc = byte_count + 1'b1;

  always_comb begin
    state_next      = state;
    byte_count_next = byte_count;
    emit            = 1'b0;
    kind_next       = KIND_DATA;
    data_next       = '0;
    length_next     = byte_count;
    payload         = 1'b0;
    if (state != ST_ESC && e.is_start) begin
      // an unescaped start inside a frame aborts it and reopens
      state_next      = ST_RX;
      byte_count_next = '0;
      if (state == ST_RX) begin
        emit      = 1'b1;
        kind_next = KIND_ABORT;
      end
    end else if (state == ST_RX) begin
      if (e.is_escape) begin
        state_next = ST_ESC;
      end else if (e.is_stop) begin
        emit            = 1'b1;
        kind_next       = KIND_END;
        state_next      = ST_IDLE;
        byte_count_next = '0;
      end else begin
        payload = 1'b1;
      end
    end else if (state == ST_ESC) begin
      payload = 1'b1;
    end else begin
      state_next = ST_IDLE;
    end
    if (payload) begin
      emit = 1'b1;
      if (byte_count >= limit) begin
        kind_next       = KIND_OVER;
        state_next      = ST_IDLE;
        byte_count_next = '0;
      end else begin
        kind_next       = KIND_DATA;
        data_next       = e.rx_byte;
        length_next     = count_inc;
        state_next      = ST_RX;
        byte_count_next = count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      byte_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (pop) begin
        state      <= state_next;
        byte_count <= byte_count_next;
        out_valid  <= emit;
        if (emit) begin
          kind         <= kind_next;
          data_byte    <= data_next;
          frame_length <= length_next;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### src/escape_byte_stuffing_deframer_top.sv
// an accepted byte is written into the queue, and the back end then registers its result item
// throughput: one byte per cycle while the queue is not full, set by the back end's state update
// a queue of QUEUE_DEPTH entries (four by default) between front and back absorbs output stalls
// reset: synchronous, clears the queue, receive state, byte count and output valid,
//   and loads the start, stop, escape and limit registers with their defaults
module escape_byte_stuffing_deframer_top #(
  parameter int MAX_FRAME_BYTES = ebsd_pkg::DEF_MAX_FRAME_BYTES,
  parameter int QUEUE_DEPTH     = ebsd_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ebsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ebsd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ebsd_pkg::BYTE_W-1:0]     rx_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ebsd_pkg::KIND_W-1:0]     kind,
  output logic [ebsd_pkg::BYTE_W-1:0]     data_byte,
  output logic [ebsd_pkg::LEN_W-1:0]      frame_length
);
  import ebsd_pkg::*;

  logic [BYTE_W-1:0] start_byte;
  logic [BYTE_W-1:0] stop_byte;
  logic [BYTE_W-1:0] escape_byte;
  logic [LEN_W-1:0]  frame_limit;
  logic              q_full;
  logic              q_push;
  logic              q_pop;
  entry_t            q_entry;
  q_head_t           q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte  <= RST_START_BYTE;
      stop_byte   <= RST_STOP_BYTE;
      escape_byte <= RST_ESCAPE_BYTE;
      frame_limit <= RST_FRAME_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_BYTE:  start_byte  <= cfg_data[BYTE_W-1:0];
        REG_STOP_BYTE:   stop_byte   <= cfg_data[BYTE_W-1:0];
        REG_ESCAPE_BYTE: escape_byte <= cfg_data[BYTE_W-1:0];
        REG_FRAME_LIMIT: frame_limit <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  ebsd_front u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .rx_byte     (rx_byte),
    .start_byte  (start_byte),
    .stop_byte   (stop_byte),
    .escape_byte (escape_byte),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_entry     (q_entry)
  );

  ebsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head)
  );

  ebsd_back #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (q_head),
    .pop          (q_pop),
    .frame_limit  (frame_limit),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .data_byte    (data_byte),
    .frame_length (frame_length)
  );

endmodule

### src/ebsd_checker.sv
module ebsd_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [ebsd_pkg::KIND_W-1:0]     kind,
  input logic [ebsd_pkg::BYTE_W-1:0]     data_byte,
  input logic [ebsd_pkg::LEN_W-1:0]      frame_length
);
  import ebsd_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(data_byte)
      && $stable(frame_length))
    else $error("result changed under stall");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown after reset");

  // only data items carry a byte
  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_DATA |-> data_byte == '0)
    else $error("non-data item with nonzero byte");

  // a data item counts itself
  a_data_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_DATA |-> frame_length != '0)
    else $error("data item with zero length");

  // a result cannot appear in the first cycle out of reset
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("result too early after reset");

endmodule

bind escape_byte_stuffing_deframer_top ebsd_checker u_ebsd_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .kind         (kind),
  .data_byte    (data_byte),
  .frame_length (frame_length)
);
